>>> rtl/wsf_pkg.sv
// ----------------------------------------------------------------------------
// wsf_pkg: shared types, constants and tap generation
// Word types, accumulator sizing and the build-time Blackman-windowed sinc
// coefficient calculation in Q30 fixed point.
// ----------------------------------------------------------------------------
`default_nettype none

package wsf_pkg;

  localparam int TAP_COUNT  = 51;
  localparam int CUTOFF_Q16 = 16384;
  localparam int CENTER_TAP = (TAP_COUNT - 1) / 2;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = 40;
  localparam int ROUND_SH = 17;
  localparam int SCALED_W = ACC_W + 1 - ROUND_SH;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // per-cell control; shift is common to every cell, clear is held off in cell 0
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] TAP_SPAN    = 64'(TAP_COUNT - 1);
  localparam longint      Q30_SCALE   = 64'sd1073741824;
  localparam longint      INV_PI_Q30  = 64'sd341782638;
  localparam longint      WIN_A0_Q30  = 64'sd450971566;
  localparam longint      WIN_A2_Q30  = 64'sd85899346;
  localparam longint      COEF_MAX    = 64'sd131071;
  localparam longint      COEF_MIN    = -64'sd131072;

  // shift-subtract divide, used only while building the taps
  function automatic logic [63:0] udiv_slow(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] taylor_sin(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] v;
    x2 = (x * x) >> 30;
    v  = Q30_ONE;
    v  = Q30_ONE - ((v * x2) >> 30) / 110;
    v  = Q30_ONE - ((v * x2) >> 30) / 72;
    v  = Q30_ONE - ((v * x2) >> 30) / 42;
    v  = Q30_ONE - ((v * x2) >> 30) / 20;
    v  = Q30_ONE - ((v * x2) >> 30) / 6;
    return (x * v) >> 30;
  endfunction

  function automatic logic [63:0] taylor_cos(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] v;
    x2 = (x * x) >> 30;
    v  = Q30_ONE;
    v  = Q30_ONE - ((v * x2) >> 30) / 132;
    v  = Q30_ONE - ((v * x2) >> 30) / 90;
    v  = Q30_ONE - ((v * x2) >> 30) / 56;
    v  = Q30_ONE - ((v * x2) >> 30) / 30;
    v  = Q30_ONE - ((v * x2) >> 30) / 12;
    v  = Q30_ONE - ((v * x2) >> 30) / 2;
    return v;
  endfunction

  // sine of a 32-bit turn phase, Q30
  function automatic longint sin_turn(input logic [31:0] p);
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] mag;
    logic        use_cos;
    r       = {34'd0, p[29:0]};
    use_cos = p[30];
    if (r > (Q30_ONE >> 1)) begin
      r       = Q30_ONE - r;
      use_cos = !use_cos;
    end
    x   = (r * PI_HALF_Q30) >> 30;
    mag = use_cos ? taylor_cos(x) : taylor_sin(x);
    return p[31] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic [31:0] window_phase(input logic [63:0] num);
    logic [63:0] p;
    p = ((num << 33) / TAP_SPAN + 64'd1) >> 1;
    return p[31:0];
  endfunction

  function automatic coef_t make_tap(input int i);
    longint      k;
    longint      ak;
    longint      h;
    longint      w;
    longint      t;
    longint      s;
    longint      c1;
    longint      c2;
    longint      res;
    logic [63:0] mag;
    logic [63:0] rq;
    logic [31:0] ph;
    k  = longint'(i) - longint'(CENTER_TAP);
    ak = (k < 0) ? -k : k;
    if (ak == 0) begin
      h = longint'(CUTOFF_Q16) << 14;
    end else begin
      ph  = 32'((ak * longint'(CUTOFF_Q16)) << 15);
      s   = sin_turn(ph);
      h   = (s * INV_PI_Q30) / Q30_SCALE;
      mag = udiv_slow((h < 0) ? -h : h, ak);
      h   = (h < 0) ? -$signed(mag) : $signed(mag);
    end
    if (i == 0 || i == TAP_COUNT - 1) begin
      w = 0;
    end else begin
      c1 = sin_turn(window_phase(64'(i)) + 32'h4000_0000);
      c2 = sin_turn(window_phase(64'(2 * i)) + 32'h4000_0000);
      w  = WIN_A0_Q30 - c1 / 2 + (c2 * WIN_A2_Q30) / Q30_SCALE;
    end
    t   = (h * w) / Q30_SCALE;
    mag = (t < 0) ? -t : t;
    rq  = (mag + 64'd4096) >> 13;
    res = (t < 0) ? -$signed(rq) : $signed(rq);
    if (res > COEF_MAX) res = COEF_MAX;
    if (res < COEF_MIN) res = COEF_MIN;
    return coef_t'(res);
  endfunction

endpackage

`default_nettype wire

>>> rtl/wsf_stream_if.sv
// ----------------------------------------------------------------------------
// wsf_stream_if: sample and result channels
// Valid/ready channels carrying one input word and one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsf_in_if import wsf_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_in;
  logic    last_in_block;

  modport source (output valid, output sample_in, output last_in_block, input ready);
  modport sink   (input valid, input sample_in, input last_in_block, output ready);
endinterface

interface wsf_out_if import wsf_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    block_end;

  modport source (output valid, output sample_out, output block_end, input ready);
  modport sink   (input valid, input sample_out, input block_end, output ready);
endinterface

`default_nettype wire

>>> rtl/wsf_cell.sv
// ----------------------------------------------------------------------------
// wsf_cell: one tap of the transposed-form chain
// Holds one partial sum; adds its tap product to the neighbor's sum.
// ----------------------------------------------------------------------------
`default_nettype none

module wsf_cell import wsf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cell_ctl_t ctl,
  input  wire sample_t   x,
  input  wire coef_t     coef,
  input  wire acc_t      sum_in,
  output      acc_t      sum
);

  prod_t prod;
  acc_t  sum_next;

  always_comb begin
    prod     = coef * x;
    sum_next = sum_in + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctl.shift) begin
      sum <= ctl.clear ? '0 : sum_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/wsf_round.sv
// ----------------------------------------------------------------------------
// wsf_round: output rounding and saturation register
// Rounds the 40-bit sum half up to Q1.15 and clamps to 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module wsf_round import wsf_pkg::*; (
  input  wire logic    clk,
  input  wire logic    load,
  input  wire acc_t    acc,
  input  wire logic    last,
  output      sample_t sample_out,
  output      logic    block_end
);

  logic signed [ACC_W:0]      biased;
  logic signed [SCALED_W-1:0] scaled;
  sample_t                    sat;

  always_comb begin
    biased = {acc[ACC_W-1], acc} + (ACC_W + 1)'(1 << (ROUND_SH - 1));
    scaled = biased[ACC_W:ROUND_SH];
    // overflow when the bits above the result disagree with its sign
    if (scaled[SCALED_W-1:SAMPLE_W-1] == '0 || scaled[SCALED_W-1:SAMPLE_W-1] == '1) begin
      sat = scaled[SAMPLE_W-1:0];
    end else begin
      sat = scaled[SCALED_W-1] ? {1'b1, {(SAMPLE_W - 1){1'b0}}} : {1'b0, {(SAMPLE_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sample_out <= sat;
      block_end  <= last;
    end
  end

endmodule

`default_nettype wire

>>> rtl/windowed_sinc_lowpass_fir_top.sv
// ----------------------------------------------------------------------------
// windowed_sinc_lowpass_fir_top: 51-tap Blackman-windowed sinc low-pass FIR
// Transposed-form chain of tap cells with rounding and saturation to Q1.15.
// ----------------------------------------------------------------------------
//
//   channel     dir  payload                         word
//   sample_ch   in   sample_in[15:0], last_in_block  one input sample
//   result_ch   out  sample_out[15:0], block_end     one filtered sample
//
// one word per cycle sustained while result_ch does not stall; a result word is
// valid on result_ch after its sample is accepted into the tap sum register and
// then loaded into the rounding register
// rate is set by the tap chain: every cell updates once per accepted word
// reset clears all partial sums at once, so no clearing pass is needed
// a stalled result_ch holds the output register; one more word is taken into
// the tap sum register before sample_ch drops ready
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_sinc_lowpass_fir_top import wsf_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  wsf_in_if.sink   sample_ch,
  wsf_out_if.source result_ch
);

  // partial sums; the slot past the last cell is a constant zero
  acc_t      cell_sum [TAP_COUNT+1];
  cell_ctl_t cell_ctl [TAP_COUNT];

  logic accept;
  logic stall;
  logic sum_valid;   // cell 0 holds a finished sum
  logic sum_last;    // block flag riding with that sum
  logic out_valid;
  logic load;

  // output register blocked by the sink
  assign stall           = out_valid && !result_ch.ready;
  assign sample_ch.ready = !sum_valid || !stall;
  assign accept          = sample_ch.valid && sample_ch.ready;
  assign load            = sum_valid && !stall;
  assign result_ch.valid = out_valid;

  assign cell_sum[TAP_COUNT] = '0;

  // the chain: cell 0 yields the filter sum, later cells hold history sums
  for (genvar g = 0; g < TAP_COUNT; g++) begin : g_tap
    localparam coef_t TAP_COEF = make_tap(g);

    always_comb begin
      cell_ctl[g].shift = accept;
      // end of block wipes history but not the sum being produced
      cell_ctl[g].clear = (g != 0) && sample_ch.last_in_block;
    end

    wsf_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (cell_ctl[g]),
      .x      (sample_ch.sample_in),
      .coef   (TAP_COEF),
      .sum_in (cell_sum[g+1]),
      .sum    (cell_sum[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (accept) begin
      sum_valid <= 1'b1;
    end else if (!stall) begin
      sum_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sum_last <= sample_ch.last_in_block;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!stall) begin
      out_valid <= sum_valid;
    end
  end

  wsf_round u_round (
    .clk        (clk),
    .load       (load),
    .acc        (cell_sum[0]),
    .last       (sum_last),
    .sample_out (result_ch.sample_out),
    .block_end  (result_ch.block_end)
  );

`ifndef SYNTHESIS
  // a block end leaves every history sum at zero
  a_block_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && sample_ch.last_in_block) |=> (cell_sum[1] == '0))
    else $error("history not cleared after block end");

  // input back-pressure only when both stages are full and the sink stalls
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !sample_ch.ready |-> (sum_valid && out_valid && !result_ch.ready))
    else $error("input stalled without a full pipeline");

  // a finished sum moves to the output when the output is free
  a_sum_moves: assert property (@(posedge clk) disable iff (rst)
    (sum_valid && !stall) |=> out_valid)
    else $error("finished sum lost");

  // history sums change only on an accepted word
  a_chain_hold: assert property (@(posedge clk) disable iff (rst)
    (!accept && !$past(rst)) |=> $stable(cell_sum[1]))
    else $error("tap chain moved without input");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_windowed_sinc_lowpass_fir_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_windowed_sinc_lowpass_fir_top: self-checking bench for the 51-tap FIR
// Builds its own Blackman-windowed sinc taps in Q30 fixed point, predicts
// every filtered word from the accepted sample stream and compares each
// result word field by field under directed, random, stalled and
// back-pressured traffic.
// ----------------------------------------------------------------------------

module tb_windowed_sinc_lowpass_fir_top import wsf_pkg::*; ();

  localparam int CLK_HALF       = 2;     // 4 ns period
  localparam int RESET_CYCLES   = 10;
  localparam int RESULT_LATENCY = 2;     // tap sum register, then rounding register
  localparam int MAX_SEND_GAP   = 40;    // longest sender idle stretch
  localparam int HOLD_CYCLES    = 150;   // long receiver hold-off
  localparam int IDLE_LIMIT     = 1000;  // cycles with no word moving on either side
  localparam int REPORT_MAX     = 10;

  localparam sample_t FULL_POS = 16'sh7fff;
  localparam sample_t FULL_NEG = 16'sh8000;

  // fixed-point constants of the tap generator
  localparam logic [63:0] ONE_Q30      = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
  localparam longint      RECIP_PI_Q30 = 64'sd341782638;
  localparam longint      BLK_A0_Q30   = 64'sd450971566;
  localparam longint      BLK_A2_Q30   = 64'sd85899346;
  localparam longint      Q30_DIV      = 64'sd1073741824;

  // content of one random block of samples
  typedef enum int {
    SIG_WHITE,
    SIG_DC,
    SIG_SQUARE,
    SIG_QUIET,
    SIG_RAMP,
    SIG_ALTERNATE
  } signal_style_t;

  typedef struct {
    sample_t sample;
    logic    block_end;
  } filtered_word_t;

  logic clk = 1'b0;
  logic rst;

  wsf_in_if  sample_ch ();
  wsf_out_if result_ch ();

  windowed_sinc_lowpass_fir_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .result_ch (result_ch)
  );

  always #(CLK_HALF) clk = ~clk;

  // predictor state: coefficient table and past samples
  coef_t   fir_taps    [TAP_COUNT];
  sample_t fir_history [TAP_COUNT-1];

  // filtered words still owed by the block, oldest first
  filtered_word_t filtered_q [$];
  filtered_word_t want;

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  hold_request   = 1'b0;
  int  mismatches     = 0;
  int  in_words       = 0;
  int  out_words      = 0;
  int  block_ends     = 0;
  int  saturated      = 0;
  int  stall_cycles   = 0;

  // --------------------------------------------------------------------------
  // tap generation in Q30, all products and quotients truncating toward zero
  // --------------------------------------------------------------------------

  // nested Taylor series: odd terms give sine, even terms give cosine
  // divisors are (2n)(2n+1) for sine and (2n)(2n-1) for cosine
  function automatic logic [63:0] taylor_nested(input logic [63:0] x, input bit odd);
    logic [63:0] x2;
    logic [63:0] v;
    logic [63:0] d;
    x2 = (x * x) >> 30;
    v  = ONE_Q30;
    for (int n = (odd ? 5 : 6); n >= 1; n--) begin
      d = odd ? 64'(2 * n * (2 * n + 1)) : 64'(2 * n * (2 * n - 1));
      v = ONE_Q30 - ((v * x2) >> 30) / d;
    end
    return odd ? (x * v) >> 30 : v;
  endfunction

  // sine of a 32-bit turn phase; quadrant from the top bits, octant fold below
  function automatic longint turn_sine(input logic [31:0] p);
    logic [63:0] r;
    logic [63:0] mag;
    bit          cosine;
    r      = 64'(p[29:0]);
    cosine = p[30];
    if (r > (ONE_Q30 >> 1)) begin
      r      = ONE_Q30 - r;
      cosine = ~cosine;
    end
    mag = taylor_nested((r * HALF_PI_Q30) >> 30, !cosine);
    return p[31] ? -longint'(mag) : longint'(mag);
  endfunction

  // num / (taps - 1) turns, rounded to the nearest 2^-32 turn
  function automatic logic [31:0] blackman_phase(input logic [63:0] num);
    logic [63:0] span;
    logic [63:0] t;
    span = 64'(TAP_COUNT - 1);
    t    = ((num << 33) / span + 64'd1) >> 1;
    return t[31:0];
  endfunction

  function automatic coef_t blackman_sinc_tap(input int idx);
    longint      tap_offs;
    longint      sinc;
    longint      win;
    longint      prod;
    longint      rnd;
    logic [63:0] mag;
    logic [63:0] ph;
    tap_offs = longint'(idx) - longint'((TAP_COUNT - 1) / 2);
    if (tap_offs < 0) tap_offs = -tap_offs;
    if (tap_offs == 0) begin
      sinc = longint'(CUTOFF_Q16) << 14;
    end else begin
      ph   = (64'(tap_offs) * 64'(CUTOFF_Q16)) << 15;
      sinc = (turn_sine(ph[31:0]) * RECIP_PI_Q30) / Q30_DIV;
      sinc = sinc / tap_offs;
    end
    // window is exactly zero on both end taps
    if (idx == 0 || idx == TAP_COUNT - 1) begin
      win = 0;
    end else begin
      win = BLK_A0_Q30 - turn_sine(blackman_phase(64'(idx)) + 32'h4000_0000) / 2
          + (turn_sine(blackman_phase(64'(2 * idx)) + 32'h4000_0000) * BLK_A2_Q30) / Q30_DIV;
    end
    prod = (sinc * win) / Q30_DIV;
    mag  = (prod < 0) ? -prod : prod;
    // round half away from zero to Q1.17, then clamp
    rnd  = longint'((mag + 64'd4096) >> 13);
    if (prod < 0) rnd = -rnd;
    if (rnd > COEF_MAX) rnd = COEF_MAX;
    if (rnd < COEF_MIN) rnd = COEF_MIN;
    return coef_t'(rnd);
  endfunction

  // --------------------------------------------------------------------------
  // filter prediction
  // --------------------------------------------------------------------------

  // one accepted sample in, one filtered word out; advances the history
  function automatic filtered_word_t predict_filtered(input sample_t x, input logic last);
    logic signed [39:0] acc;
    longint             y;
    filtered_word_t     r;
    acc = 40'(longint'(fir_taps[0]) * longint'(x));
    for (int i = 1; i < TAP_COUNT; i++)
      acc = acc + 40'(longint'(fir_taps[i]) * longint'(fir_history[i-1]));
    // Q2.32 to Q1.15, rounding half up, then saturate
    y = (longint'(acc) + 64'sd65536) >>> 17;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    // last-of-block flag empties the history after its own sample
    if (last) begin
      for (int i = 0; i < TAP_COUNT - 1; i++) fir_history[i] = '0;
    end else begin
      for (int i = TAP_COUNT - 2; i > 0; i--) fir_history[i] = fir_history[i-1];
      fir_history[0] = x;
    end
    r.sample    = sample_t'(y);
    r.block_end = last;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // sample side
  // --------------------------------------------------------------------------

  // offer one word after a random idle stretch; valid stays high afterwards so
  // back-to-back words go out without an idle gap
  task automatic send_word(input sample_t s, input logic last);
    int gap;
    gap = 0;
    while (gap < MAX_SEND_GAP && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.sample_in     <= s;
    sample_ch.last_in_block <= last;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    in_words++;
    if (last) block_ends++;
    want = predict_filtered(s, last);
    if (want.sample == FULL_POS || want.sample == FULL_NEG) saturated++;
    filtered_q.push_back(want);
  endtask

  // stop offering and let every owed word come out
  task automatic drain_results();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  // blocks of shaped content, mostly closed by a last-of-block flag, with
  // stray flags and unterminated blocks mixed in
  task automatic run_random_blocks(input int count);
    int            sent;
    int            len;
    int            period;
    signal_style_t style;
    sample_t       level;
    sample_t       step;
    sample_t       s;
    logic          last;
    sent = 0;
    while (sent < count) begin
      len    = ($urandom_range(9) == 0) ? $urandom_range(220, 81) : $urandom_range(80, 1);
      if (len > count - sent) len = count - sent;
      style  = signal_style_t'($urandom_range(5));
      period = $urandom_range(40, 1);
      step   = sample_t'($urandom_range(2047)) - 16'sd1024;
      case ($urandom_range(2))
        0:       level = FULL_POS;
        1:       level = FULL_NEG;
        default: level = sample_t'($urandom);
      endcase
      for (int j = 0; j < len; j++) begin
        case (style)
          SIG_WHITE:     s = sample_t'($urandom);
          SIG_DC:        s = level;
          SIG_SQUARE:    s = ((j / period) % 2) ? level : ~level;
          SIG_QUIET:     s = sample_t'($urandom_range(255)) - 16'sd128;
          SIG_RAMP:      s = sample_t'(level + step * j);
          SIG_ALTERNATE: s = (j % 2) ? FULL_POS : FULL_NEG;
          default:       s = '0;
        endcase
        last = (j == len - 1) ? ($urandom_range(4) != 0) : ($urandom_range(49) == 0);
        send_word(s, last);
        sent++;
      end
    end
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // result side
  // --------------------------------------------------------------------------

  // ready changes on the falling edge; a hold-off request blocks it for a
  // long counted stretch while the sender keeps offering
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic log_mismatch(input string what, input int expv, input int actv);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%0t mismatch on result word %0d, %s: expected %0d, got %0d",
               $time, out_words, what, expv, actv);
  endtask

  // compare every accepted result word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      out_words++;
      if (filtered_q.size() == 0) begin
        log_mismatch("word with nothing owed", 0, result_ch.sample_out);
      end else begin
        want = filtered_q.pop_front();
        if (result_ch.sample_out !== want.sample)
          log_mismatch("sample_out", want.sample, result_ch.sample_out);
        if (result_ch.block_end !== want.block_end)
          log_mismatch("block_end", want.block_end, result_ch.block_end);
      end
    end
  end

  // watchdog: too long without a word moving on either channel
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= IDLE_LIMIT) begin
      $display("no word moved for %0d cycles", IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // impulse, extremes, bit patterns and history clearing, including
  // back-to-back block ends
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_word(FULL_POS, 1'b0);
    repeat (7) send_word('0, 1'b0);
    send_word(FULL_NEG, 1'b1);
    // history is empty again: zero in gives exactly zero out
    send_word('0, 1'b0);
    send_word(16'sd1, 1'b0);
    send_word(-16'sd1, 1'b0);
    send_word(16'sh5555, 1'b0);
    send_word(16'shaaaa, 1'b0);
    send_word(FULL_POS, 1'b0);
    send_word(FULL_NEG, 1'b0);
    send_word(FULL_POS, 1'b0);
    send_word(FULL_NEG, 1'b1);
    send_word(FULL_NEG, 1'b1);
    send_word(FULL_POS, 1'b1);
    send_word('0, 1'b1);
    drain_results();
  endtask

  task automatic test_random_steady();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_blocks(345);
  endtask

  task automatic test_random_sender_gaps();
    send_idle_pct  = 70;
    recv_stall_pct = 0;
    run_random_blocks(345);
  endtask

  task automatic test_random_receiver_stalls();
    send_idle_pct  = 0;
    recv_stall_pct = 70;
    run_random_blocks(345);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct  = 8;
    recv_stall_pct = 8;
    run_random_blocks(345);
  endtask

  // receiver holds off while words keep coming, so the block fills and
  // drops ready on the sample side
  task automatic test_backpressure_fill();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    for (int n = 0; n < 48; n++) send_word(sample_t'($urandom), $urandom_range(15) == 0);
    wait (!hold_request);
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst                     = 1'b1;
    sample_ch.valid         = 1'b0;
    sample_ch.sample_in     = '0;
    sample_ch.last_in_block = 1'b0;
    for (int i = 0; i < TAP_COUNT; i++) fir_taps[i] = blackman_sinc_tap(i);
    for (int i = 0; i < TAP_COUNT - 1; i++) fir_history[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_random_steady();
    test_backpressure_fill();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_both_idle();

    $display("filtered %0d samples in %0d blocks, %0d result words checked, %0d clipped",
             in_words, block_ends, out_words, saturated);
    $display("traffic: free-running, sparse sender, stalling receiver, light mix, long hold-off");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> windowed_sinc_lowpass_fir_top.f
rtl/wsf_pkg.sv
rtl/wsf_stream_if.sv
rtl/wsf_cell.sv
rtl/wsf_round.sv
rtl/windowed_sinc_lowpass_fir_top.sv
tb/sv/tb_windowed_sinc_lowpass_fir_top.sv
